### rtl/jdq_pkg.sv
package jdq_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int TIME_BITS_DEF = 16;
  localparam int TOTAL_W       = 20;

  localparam logic [2:0] MODE_PUSH_BACK  = 3'd0;
  localparam logic [2:0] MODE_PUSH_FRONT = 3'd1;
  localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [2:0] MODE_AGE        = 3'd3;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  job_kind;
    logic [15:0] arrival_time;
    logic [15:0] service_time;
    logic [15:0] initial_wait;
    logic [15:0] kind_sequence;
    logic [7:0]  query_kind;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [4:0]         entry_count;
    logic [TOTAL_W-1:0] wait_total;
    logic [15:0]        matched_sequence;
    logic [7:0]         front_kind;
    logic [15:0]        front_arrival;
    logic [15:0]        front_service;
    logic [15:0]        front_wait;
    logic [15:0]        front_sequence;
    logic [7:0]         back_kind;
    logic [15:0]        back_sequence;
  } rsp_t;

endpackage

### rtl/jdq_if.sv
interface jdq_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/jdq_store.sv
module jdq_store #(
  parameter int DEPTH = 16,
  parameter int TB    = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wkind,
  input  logic [TB-1:0] warr,
  input  logic [TB-1:0] wsvc,
  input  logic [TB-1:0] wwait,
  input  logic [15:0]   wseq,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rkind,
  output logic [TB-1:0] rarr,
  output logic [TB-1:0] rsvc,
  output logic [TB-1:0] rwait,
  output logic [15:0]   rseq
);
  localparam int EW = 8 + 3 * TB + 16;
  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= {wkind, warr, wsvc, wwait, wseq};
    rd_r <= mem[raddr];
  end

  assign {rkind, rarr, rsvc, rwait, rseq} = rd_r;
endmodule

### rtl/job_deque_with_wait_aging.sv
// Each accepted request runs a sweep over all DEPTH slots, whatever the occupancy, and then
// registers its result for the sink; one request at a time, so a new request is taken only in
// the idle state. A result held by the sink stalls the next request in the output state.
// The sweep reads every slot through the single memory read port, ageing in place.
// Front/back fields are captured during the sweep at their queue positions.
// Reset (rst_n low, synchronous) empties the queue; memory contents are not cleared.
module job_deque_with_wait_aging #(
  parameter int DEPTH     = jdq_pkg::DEPTH_DEF,
  parameter int TIME_BITS = jdq_pkg::TIME_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  jdq_if.sink   in_req,
  jdq_if.source out_rsp
);
  import jdq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [1:0] S_IDLE = 2'd0, S_SWEEP = 2'd1, S_OUT = 2'd2;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW:0] LAST = (AW + 1)'(DEPTH - 1);
  localparam logic [TIME_BITS-1:0] TMAX = '1;
  localparam logic [TOTAL_W-1:0] TOTMAX = '1;

  logic [1:0]    state_r, state_nxt;
  logic [AW-1:0] front_r;
  logic [CW-1:0] occ_r;
  req_t          req_r;
  logic [AW:0]   pos_r;      // read issue position
  logic          rv_r;       // read data valid
  logic [AW-1:0] rpos_r;     // position of data returning
  logic [TOTAL_W-1:0] tot_r;
  logic [15:0]   match_r;
  rsp_t          rsp_r;
  rsp_t          orsp_r;     // result held for the sink
  logic          ovalid_r;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wkind, rkind;
  logic [TIME_BITS-1:0] warr, wsvc, wwait, rarr, rsvc, rwait;
  logic [15:0]   wseq, rseq;

  jdq_store #(.DEPTH(DEPTH), .TB(TIME_BITS), .AW(AW)) u_store (
    .clk, .we, .waddr, .wkind, .warr, .wsvc, .wwait, .wseq,
    .raddr, .rkind, .rarr, .rsvc, .rwait, .rseq
  );

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] f, input logic [AW:0] p);
    logic [AW+1:0] s;
    s = {2'b0, f} + {1'b0, p};
    if (s >= (AW + 2)'(DEPTH)) s = s - (AW + 2)'(DEPTH);
    return s[AW-1:0];
  endfunction

  logic [AW-1:0] fdec;
  assign fdec = (front_r == '0) ? AW'(DEPTH - 1) : front_r - 1'b1;
  logic [AW-1:0] finc;
  assign finc = (front_r == AW'(DEPTH - 1)) ? '0 : front_r + 1'b1;

  logic acc;
  assign in_req.ready = (state_r == S_IDLE);
  assign acc = in_req.valid && in_req.ready;

  logic push, full;
  assign full = (occ_r == DEPTH_C);
  assign push = (in_req.data.mode == MODE_PUSH_BACK || in_req.data.mode == MODE_PUSH_FRONT);

  logic pop_ok;
  assign pop_ok = (in_req.data.mode == MODE_POP_FRONT) && (occ_r != '0);

  logic [1:0] st_acc;
  assign st_acc = (push && full) ? ST_FULL :
                  (in_req.data.mode == MODE_POP_FRONT && occ_r == '0) ? ST_EMPTY : ST_DONE;

  rsp_t rsp_clr;
  always_comb begin
    rsp_clr = '0;
    rsp_clr.status = st_acc;
  end

  logic in_q, aging, wsat;
  assign in_q  = ({1'b0, rpos_r} < (AW + 1)'(occ_r));
  assign aging = rv_r && in_q && (req_r.mode == MODE_AGE);
  assign wsat  = (rwait == TMAX);
  logic [TIME_BITS-1:0] wcur;
  assign wcur = (aging && !wsat) ? rwait + 1'b1 : rwait;

  always_comb begin
    we = 1'b0; waddr = slot(front_r, {1'b0, rpos_r});
    wkind = rkind; warr = rarr; wsvc = rsvc; wwait = wcur; wseq = rseq;
    if (acc && push && !full) begin
      we = 1'b1;
      waddr = (in_req.data.mode == MODE_PUSH_BACK) ? slot(front_r, (AW + 1)'(occ_r)) : fdec;
      wkind = in_req.data.job_kind;
      warr  = TIME_BITS'(in_req.data.arrival_time);
      wsvc  = TIME_BITS'(in_req.data.service_time);
      wwait = TIME_BITS'(in_req.data.initial_wait);
      wseq  = in_req.data.kind_sequence;
    end else if (aging) begin
      we = 1'b1;
    end
  end
  assign raddr = slot(front_r, pos_r);

  logic [TOTAL_W:0] tsum;
  assign tsum = {1'b0, tot_r} + (TOTAL_W + 1)'(wcur);

  rsp_t rsp_fin;
  always_comb begin
    rsp_fin = rsp_r;
    rsp_fin.entry_count = 5'(occ_r);
    rsp_fin.wait_total = tot_r;
    rsp_fin.matched_sequence = match_r;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (acc) state_nxt = S_SWEEP;
      S_SWEEP: if (rv_r && {1'b0, rpos_r} == LAST) state_nxt = S_OUT;
      S_OUT:   if (!ovalid_r || out_rsp.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; front_r <= '0; occ_r <= '0; ovalid_r <= 1'b0;
      rv_r <= 1'b0; pos_r <= '0;
    end else begin
      state_r <= state_nxt;
      rv_r <= (state_r == S_SWEEP) && (pos_r <= LAST);
      rpos_r <= pos_r[AW-1:0];
      if (acc) begin
        req_r <= in_req.data; pos_r <= '0; tot_r <= '0; match_r <= '0;
        rsp_r <= rsp_clr;
        if (push && !full) occ_r <= occ_r + 1'b1;
        if (in_req.data.mode == MODE_PUSH_FRONT && !full) front_r <= fdec;
        if (pop_ok) begin
          occ_r <= occ_r - 1'b1; front_r <= finc;
        end
      end
      if (state_r == S_SWEEP && pos_r <= LAST) pos_r <= pos_r + 1'b1;
      if (rv_r && in_q) begin
        tot_r <= tsum[TOTAL_W] ? TOTMAX : tsum[TOTAL_W-1:0];
        if (rkind == req_r.query_kind) match_r <= rseq;
        if (rpos_r == '0) begin
          rsp_r.front_kind <= rkind;
          rsp_r.front_arrival <= 16'(rarr);
          rsp_r.front_service <= 16'(rsvc);
          rsp_r.front_wait <= 16'(wcur);
          rsp_r.front_sequence <= rseq;
        end
        if ({1'b0, rpos_r} == (AW + 1)'(occ_r) - 1'b1) begin
          rsp_r.back_kind <= rkind;
          rsp_r.back_sequence <= rseq;
        end
      end
      if (state_r == S_OUT && state_nxt == S_IDLE) begin
        ovalid_r <= 1'b1;
        orsp_r <= rsp_fin;
      end else if (ovalid_r && out_rsp.ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  assign out_rsp.valid = ovalid_r;
  assign out_rsp.data  = orsp_r;

  a_occ: assert property (@(posedge clk) disable iff (!rst_n) occ_r <= DEPTH_C)
    else $error("occupancy beyond depth");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> state_r == S_SWEEP) else $error("request not swept");
  a_rej: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && push && full) |=> $stable(occ_r)) else $error("full push changed queue");
endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import jdq_pkg::*;

  localparam int DEPTH = 16;
  localparam logic [2:0] MODE_QUERY = 3'd4;

  logic clk;
  logic rst_n;

  jdq_if #(.T(req_t)) req_ch ();
  jdq_if #(.T(rsp_t)) rsp_ch ();

  job_deque_with_wait_aging dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_req(req_ch.sink),
    .out_rsp(rsp_ch.source)
  );

  // predictor state
  logic [7:0]  jq_kind [DEPTH];
  logic [15:0] jq_arr [DEPTH];
  logic [15:0] jq_svc [DEPTH];
  logic [15:0] jq_wait [DEPTH];
  logic [15:0] jq_seq [DEPTH];
  int unsigned jq_front;
  int unsigned jq_count;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int   mismatches;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   hold_cycles;
  bit   stim_done;

  function automatic rsp_t apply_request(req_t r);
    rsp_t o;
    int unsigned s;
    int unsigned tot;
    o = '0;
    tot = 0;
    if (r.mode == MODE_PUSH_BACK || r.mode == MODE_PUSH_FRONT) begin
      if (jq_count >= DEPTH) begin
        o.status = ST_FULL;
      end else begin
        if (r.mode == MODE_PUSH_BACK) begin
          s = (jq_front + jq_count) % DEPTH;
        end else begin
          jq_front = (jq_front + DEPTH - 1) % DEPTH;
          s = jq_front;
        end
        jq_kind[s] = r.job_kind;
        jq_arr[s] = r.arrival_time;
        jq_svc[s] = r.service_time;
        jq_wait[s] = r.initial_wait;
        jq_seq[s] = r.kind_sequence;
        jq_count++;
      end
    end else if (r.mode == MODE_POP_FRONT) begin
      if (jq_count == 0) begin
        o.status = ST_EMPTY;
      end else begin
        jq_front = (jq_front + 1) % DEPTH;
        jq_count--;
      end
    end else if (r.mode == MODE_AGE) begin
      for (int i = 0; i < jq_count; i++) begin
        s = (jq_front + i) % DEPTH;
        if (jq_wait[s] != 16'hffff) jq_wait[s]++;
      end
    end
    for (int i = 0; i < jq_count; i++) begin
      s = (jq_front + i) % DEPTH;
      tot += jq_wait[s];
      if (tot > 20'hfffff) tot = 20'hfffff;
      if (jq_kind[s] == r.query_kind) o.matched_sequence = jq_seq[s];
    end
    o.entry_count = jq_count[4:0];
    o.wait_total = tot[19:0];
    if (jq_count > 0) begin
      s = (jq_front + jq_count - 1) % DEPTH;
      o.front_kind = jq_kind[jq_front];
      o.front_arrival = jq_arr[jq_front];
      o.front_service = jq_svc[jq_front];
      o.front_wait = jq_wait[jq_front];
      o.front_sequence = jq_seq[jq_front];
      o.back_kind = jq_kind[s];
      o.back_sequence = jq_seq[s];
    end
    return o;
  endfunction

  function automatic req_t make_req(logic [2:0] mode);
    req_t r;
    r.mode = mode;
    r.job_kind = 8'($urandom_range(0, 5));
    if ($urandom_range(0, 3) == 0) r.job_kind = 8'($urandom);
    r.arrival_time = 16'($urandom);
    r.service_time = 16'($urandom);
    case ($urandom_range(0, 3))
      0: r.initial_wait = 16'(16'hffff - $urandom_range(0, 3));
      1: r.initial_wait = 16'($urandom_range(0, 10));
      default: r.initial_wait = 16'($urandom);
    endcase
    r.kind_sequence = $urandom_range(0, 7) == 0 ? 16'd0 : 16'($urandom);
    r.query_kind = 8'($urandom_range(0, 5));
    if ($urandom_range(0, 5) == 0) r.query_kind = 8'($urandom);
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    req_t r;
    rst_n = 1'b0;
    send_idle_pct = 18;
    recv_idle_pct = 84;
    hold_cycles = 0;
    stim_done = 1'b0;
    // directed: empty pop/age, fill past full, saturating waits, all modes
    r = make_req(MODE_POP_FRONT);
    pending_reqs.push_back(r);
    pending_reqs.push_back(make_req(MODE_AGE));
    for (int i = 0; i < 17; i++) begin
      r = make_req(i[0] ? MODE_PUSH_FRONT : MODE_PUSH_BACK);
      r.initial_wait = (i < 3) ? 16'hffff : 16'hfff0;
      r.job_kind = (i == 4) ? 8'hff : 8'(i % 3);
      r.arrival_time = i[1] ? 16'hffff : 16'h0000;
      r.service_time = i[1] ? 16'h0000 : 16'hffff;
      pending_reqs.push_back(r);
    end
    pending_reqs.push_back(make_req(MODE_AGE));
    r = make_req(MODE_QUERY);
    r.query_kind = 8'hff;
    pending_reqs.push_back(r);
    for (logic [2:0] m = 3'd5; m != 3'd0; m++) pending_reqs.push_back(make_req(m));
    pending_reqs.push_back(make_req(MODE_POP_FRONT));
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    // random: biased to swing the fill level between empty and full
    for (int p = 0; p < 3; p++) begin
      for (int i = 0; i < 560; i++) begin
        int k;
        k = $urandom_range(0, 99);
        if (((i / 40) % 2) == 0)
          r = make_req(k < 55 ? 3'($urandom_range(0, 1)) :
                       k < 70 ? MODE_POP_FRONT : k < 85 ? MODE_AGE : 3'($urandom_range(4, 7)));
        else
          r = make_req(k < 15 ? 3'($urandom_range(0, 1)) :
                       k < 70 ? MODE_POP_FRONT : k < 85 ? MODE_AGE : 3'($urandom_range(4, 7)));
        pending_reqs.push_back(r);
      end
      while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge clk);
      if (p == 0) begin
        send_idle_pct = 84;
        recv_idle_pct = 18;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles = 300;
      end
    end
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("end of test: mismatches");
    $finish;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
      req_ch.data <= '0;
      jq_front = 0;
      jq_count = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        expected_rsps.push_back(apply_request(pending_reqs.pop_front()));
      end
      if (pending_reqs.size() != 0 && (($urandom_range(0, 99) >= send_idle_pct) ||
          (req_ch.valid && !req_ch.ready))) begin
        req_ch.valid <= 1'b1;
        req_ch.data <= pending_reqs[0];
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
      mismatches = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected response %p", rsp_ch.data);
        end else begin
          rsp_t e;
          e = expected_rsps.pop_front();
          if (e !== rsp_ch.data) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch exp %p got %p", e, rsp_ch.data);
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

endmodule
